### design/weighted_spatial_spread_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the weighted spatial spread core
// Both macros assume a clock named clk; WSSC_ASSERT_RUN also an active-low reset named rst_n.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_SPATIAL_SPREAD_CORE_DEFINES_SVH
`define WEIGHTED_SPATIAL_SPREAD_CORE_DEFINES_SVH

// Check outside reset only
`define WSSC_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included
`define WSSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/wssc_pkg.sv
// ---------------------------------------------------------------------------
// wssc_pkg
// Shared types and constants of the weighted spatial spread core.
// ---------------------------------------------------------------------------
package wssc_pkg;

  localparam int unsigned MAX_STATES_DEF  = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 47;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned CUTOFF_W   = 47;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_STEP_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_STEP_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_STEP_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_CUTOFF = 3'd3;

  localparam logic [STEP_W-1:0]   STEP_RESET   = 16'd4096;
  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = '0;

  localparam logic [12:0] COUNT_MAX = 13'd8191;
  localparam logic [63:0] SQ_CAP    = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic signed [15:0] amplitude;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
    logic               last_of_state;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        state_index;
    logic signed [47:0] spread;
    logic               delocalized;
    logic [12:0]        delocalized_count;
  } out_item_t;

  // Finished sums of one state, handed from front to back
  typedef struct packed {
    logic signed [63:0] sum_x;
    logic signed [63:0] sum_y;
    logic signed [63:0] sum_z;
    logic [63:0]        sum_squares;
  } snap_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step_x;
    logic [STEP_W-1:0]   step_y;
    logic [STEP_W-1:0]   step_z;
    logic [CUTOFF_W-1:0] spread_cutoff;
  } cfg_t;

endpackage

### design/wssc_fifo.sv
// ---------------------------------------------------------------------------
// wssc_fifo
// Short queue of finished state sums between the accumulating front and the
// finishing back.
// ---------------------------------------------------------------------------
module wssc_fifo #(
  parameter int unsigned DEPTH = wssc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wssc_pkg::snap_t wr_data,
  output logic            full,
  input  logic            pop,
  output wssc_pkg::snap_t rd_data,
  output logic            empty
);
  import wssc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  snap_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### design/wssc_front.sv
// ---------------------------------------------------------------------------
// wssc_front
// Sample intake: weight and product pipeline feeding saturating per-state
// accumulators; pushes the finished sums on the last sample of a state.
// ---------------------------------------------------------------------------
module wssc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wssc_pkg::in_item_t in_data,
  input  wssc_pkg::cfg_t     cfg,
  output logic               snap_push,
  output wssc_pkg::snap_t    snap_data,
  input  logic               snap_full
);
  import wssc_pkg::*;

  localparam int unsigned NAX = 3;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return $signed(s[63:0]);
  endfunction

  logic adv;
  logic [STEP_W-1:0] step_a [NAX];

  // stage 1: captured sample
  logic               v1_r, last1_r;
  logic signed [15:0] amp1_r;
  logic signed [15:0] crd1_r [NAX];
  // stage 2: weight, coordinate times step, coordinate squared
  logic               v2_r, last2_r;
  logic [30:0]        w2_r;
  logic signed [32:0] cs2_r [NAX];
  logic [30:0]        sq2_r [NAX];
  logic signed [31:0] wprod;
  logic signed [32:0] cs2_nxt [NAX];
  logic signed [31:0] sqprod [NAX];
  // stage 3: linear terms, scaled squares
  logic               v3_r, last3_r;
  logic [30:0]        w3_r;
  logic signed [30:0] lin3_r [NAX];
  logic [33:0]        t3_r [NAX];
  logic signed [64:0] linprod [NAX];
  logic [46:0]        tprod [NAX];
  // stage 4: weighted square terms
  logic               v4_r, last4_r;
  logic signed [30:0] lin4_r [NAX];
  logic [33:0]        q4_r [NAX];
  logic [64:0]        qprod [NAX];
  // stage 5: summed square terms
  logic               v5_r, last5_r;
  logic signed [30:0] lin5_r [NAX];
  logic [35:0]        qsum5_r;

  // accumulators
  logic signed [63:0] sum_r [NAX];
  logic signed [63:0] sumsq_r;
  logic signed [63:0] acc [NAX];
  logic signed [63:0] accsq;

  assign step_a[0] = cfg.step_x;
  assign step_a[1] = cfg.step_y;
  assign step_a[2] = cfg.step_z;

  // Freeze the whole pipe when a finished state finds the queue full
  assign adv       = !(v5_r && last5_r && snap_full);
  assign in_stall  = !adv;
  assign snap_push = v5_r && last5_r && adv;

  always_comb begin
    wprod = amp1_r * amp1_r;
    for (int i = 0; i < NAX; i++) begin
      cs2_nxt[i] = crd1_r[i] * $signed({1'b0, step_a[i]});
      sqprod[i]  = crd1_r[i] * crd1_r[i];
      linprod[i] = $signed({1'b0, w2_r}) * cs2_r[i];
      tprod[i]   = sq2_r[i] * step_a[i];
      qprod[i]   = t3_r[i] * w3_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      acc[i] = sat_add(sum_r[i], $signed({{33{lin5_r[i][30]}}, lin5_r[i]}));
    end
    accsq = sat_add(sumsq_r, $signed({28'd0, qsum5_r}));
  end

  assign snap_data.sum_x       = acc[0];
  assign snap_data.sum_y       = acc[1];
  assign snap_data.sum_z       = acc[2];
  assign snap_data.sum_squares = accsq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      sumsq_r <= '0;
      for (int i = 0; i < NAX; i++) begin
        sum_r[i] <= '0;
      end
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (v5_r) begin
        // clear after the last sample of a state
        sumsq_r <= last5_r ? '0 : accsq;
        for (int i = 0; i < NAX; i++) begin
          sum_r[i] <= last5_r ? '0 : acc[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      amp1_r    <= in_data.amplitude;
      crd1_r[0] <= in_data.x_coord;
      crd1_r[1] <= in_data.y_coord;
      crd1_r[2] <= in_data.z_coord;
      last1_r   <= in_data.last_of_state;

      w2_r    <= wprod[30:0];
      last2_r <= last1_r;
      w3_r    <= w2_r;
      last3_r <= last2_r;
      last4_r <= last3_r;
      last5_r <= last4_r;
      qsum5_r <= {2'd0, q4_r[0]} + {2'd0, q4_r[1]} + {2'd0, q4_r[2]};
      for (int i = 0; i < NAX; i++) begin
        cs2_r[i]  <= cs2_nxt[i];
        sq2_r[i]  <= sqprod[i][30:0];
        lin3_r[i] <= linprod[i][64:34];
        t3_r[i]   <= tprod[i][45:12];
        q4_r[i]   <= qprod[i][63:30];
        lin4_r[i] <= lin3_r[i];
        lin5_r[i] <= lin4_r[i];
      end
    end
  end

endmodule

### design/wssc_back.sv
// ---------------------------------------------------------------------------
// wssc_back
// Per-state finish: squared means through one shared multiplier, spread,
// cutoff test, state and count bookkeeping, result register.
// ---------------------------------------------------------------------------
module wssc_back #(
  parameter int unsigned MAX_STATES = wssc_pkg::MAX_STATES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wssc_pkg::cfg_t      cfg,
  input  logic                snap_empty,
  input  wssc_pkg::snap_t     snap_data,
  output logic                snap_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output wssc_pkg::out_item_t out_data
);
  import wssc_pkg::*;

  localparam int unsigned NAX  = 3;
  localparam int unsigned SN_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam logic [SN_W-1:0] SN_LAST = SN_W'(MAX_STATES - 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_DIFF = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  localparam logic [1:0] PART_HH = 2'd0;
  localparam logic [1:0] PART_HL = 2'd1;
  localparam logic [1:0] PART_LL = 2'd2;

  localparam logic [3:0] STEP_END = 4'd9;

  localparam logic signed [47:0] SPREAD_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SPREAD_MIN = 48'sh8000_0000_0000;

  logic [1:0]  bst_r, bst_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [63:0] s2_r;
  logic [38:0] mag_r [NAX];
  logic        cap_r [NAX];
  logic [45:0] prod_r, prod_nxt;
  logic [1:0]  kind_r;
  logic        pcap_r;
  logic [63:0] means_r, means_nxt;
  logic signed [47:0] spread_r, spread_nxt;
  logic [SN_W-1:0] state_r, state_nxt;
  logic [12:0] above_r, above_nxt, above_inc;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        out_load;

  logic signed [63:0] snap_sum [NAX];
  logic [63:0] abs_v [NAX];
  logic [1:0]  iss_axis;
  logic [1:0]  iss_part;
  logic [38:0] mag_sel;
  logic [22:0] op_a, op_b;
  logic [63:0] term;
  logic [64:0] diff;
  logic        deloc;
  logic [31:0] sn_ext;

  assign snap_sum[0] = snap_data.sum_x;
  assign snap_sum[1] = snap_data.sum_y;
  assign snap_sum[2] = snap_data.sum_z;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      abs_v[i] = snap_sum[i][63] ? (64'd0 - snap_sum[i]) : snap_sum[i];
    end
  end

  // Nine products: per axis high*high, high*low, low*low of the magnitude
  always_comb begin
    case (step_r)
      4'd0: begin iss_axis = 2'd0; iss_part = PART_HH; end
      4'd1: begin iss_axis = 2'd0; iss_part = PART_HL; end
      4'd2: begin iss_axis = 2'd0; iss_part = PART_LL; end
      4'd3: begin iss_axis = 2'd1; iss_part = PART_HH; end
      4'd4: begin iss_axis = 2'd1; iss_part = PART_HL; end
      4'd5: begin iss_axis = 2'd1; iss_part = PART_LL; end
      4'd6: begin iss_axis = 2'd2; iss_part = PART_HH; end
      4'd7: begin iss_axis = 2'd2; iss_part = PART_HL; end
      4'd8: begin iss_axis = 2'd2; iss_part = PART_LL; end
      default: begin iss_axis = 2'd0; iss_part = PART_HH; end
    endcase
    mag_sel = mag_r[iss_axis];
    case (iss_part)
      PART_HH: begin op_a = mag_sel[38:16];        op_b = mag_sel[38:16]; end
      PART_HL: begin op_a = mag_sel[38:16];        op_b = {7'd0, mag_sel[15:0]}; end
      PART_LL: begin op_a = {7'd0, mag_sel[15:0]}; op_b = {7'd0, mag_sel[15:0]}; end
      default: begin op_a = mag_sel[38:16];        op_b = mag_sel[38:16]; end
    endcase
    prod_nxt = op_a * op_b;
  end

  // A capped axis adds the cap once and nothing for its other parts
  always_comb begin
    case (kind_r)
      PART_HH: term = pcap_r ? SQ_CAP : {2'd0, prod_r, 16'd0};
      PART_HL: term = pcap_r ? 64'd0 : {17'd0, prod_r, 1'b0};
      PART_LL: term = pcap_r ? 64'd0 : {34'd0, prod_r[45:16]};
      default: term = 64'd0;
    endcase
  end

  assign diff      = {1'b0, s2_r} - {1'b0, means_r};
  assign deloc     = spread_r > $signed({1'b0, cfg.spread_cutoff});
  assign above_inc = (deloc && above_r != COUNT_MAX) ? above_r + 13'd1 : above_r;
  assign sn_ext    = 32'(state_r);

  always_comb begin
    bst_nxt       = bst_r;
    step_nxt      = step_r;
    means_nxt     = means_r;
    spread_nxt    = spread_r;
    state_nxt     = state_r;
    above_nxt     = above_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_load      = 1'b0;
    snap_pop      = 1'b0;
    case (bst_r)
      B_IDLE: begin
        if (!snap_empty) begin
          snap_pop  = 1'b1;
          step_nxt  = '0;
          means_nxt = '0;
          bst_nxt   = B_MUL;
        end
      end
      B_MUL: begin
        step_nxt = step_r + 4'd1;
        if (step_r != 4'd0) begin
          means_nxt = means_r + term;
        end
        if (step_r == STEP_END) begin
          bst_nxt = B_DIFF;
        end
      end
      B_DIFF: begin
        if (!diff[64] && (|diff[63:47])) begin
          spread_nxt = SPREAD_MAX;
        end else if (diff[64] && !(&diff[63:47])) begin
          spread_nxt = SPREAD_MIN;
        end else begin
          spread_nxt = $signed(diff[47:0]);
        end
        bst_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load                       = 1'b1;
          out_valid_nxt                  = 1'b1;
          out_data_nxt.state_index       = sn_ext[11:0];
          out_data_nxt.spread            = spread_r;
          out_data_nxt.delocalized       = deloc;
          out_data_nxt.delocalized_count = above_inc;
          // batch end: restart numbering and count
          if (state_r == SN_LAST) begin
            state_nxt = '0;
            above_nxt = '0;
          end else begin
            state_nxt = state_r + 1'b1;
            above_nxt = above_inc;
          end
          bst_nxt = B_IDLE;
        end
      end
      default: bst_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= B_IDLE;
      step_r      <= '0;
      state_r     <= '0;
      above_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bst_r       <= bst_nxt;
      step_r      <= step_nxt;
      state_r     <= state_nxt;
      above_r     <= above_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    kind_r   <= iss_part;
    pcap_r   <= cap_r[iss_axis];
    means_r  <= means_nxt;
    spread_r <= spread_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
    if (snap_pop) begin
      s2_r <= snap_data.sum_squares;
      for (int i = 0; i < NAX; i++) begin
        mag_r[i] <= abs_v[i][38:0];
        cap_r[i] <= |abs_v[i][63:39];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/weighted_spatial_spread_core.sv
// ---------------------------------------------------------------------------
// weighted_spatial_spread_core
// Per-state weighted spread of a sampled wavefunction with delocalisation flag.
// ---------------------------------------------------------------------------
// Input channel in_*: one grid sample per item (amplitude, x/y/z, last flag).
// Output channel out_*: one result per state, sent after its last sample.
// Both use valid/stall; an item moves on an edge with valid high, stall low.
// Samples are taken one per cycle; in_stall rises only when a finished state
// meets a full hand-off queue (two states deep).
// From the last sample of a state to its result, the sums pass a five-stage
// product pipe and accumulator, then the finishing unit, which makes nine
// passes through its single 23x23 multiplier.
// The finishing unit takes one state at a time, so a run of short states
// can fill the queue and stall the input until it drains.
// A stalled result holds in the output register; the front keeps accepting
// samples meanwhile until the queue fills.
// cfg_*: write-only register port; write it only while idle (not enforced).
// Reset (synchronous, active low) clears sums, state number, count and all
// valids, and loads register defaults (steps 1.0, cutoff 0).
// ---------------------------------------------------------------------------
module weighted_spatial_spread_core #(
  parameter int unsigned MAX_STATES  = wssc_pkg::MAX_STATES_DEF,
  parameter int unsigned QUEUE_DEPTH = wssc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  wssc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output wssc_pkg::out_item_t                out_data,
  input  logic                               cfg_wr_en,
  input  logic [wssc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wssc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import wssc_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  snap_t push_data, head_data;
  logic  snap_push, snap_pop, snap_full, snap_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_AXIS_STEP_X:   cfg_nxt.step_x        = cfg_wdata[STEP_W-1:0];
        CFG_AXIS_STEP_Y:   cfg_nxt.step_y        = cfg_wdata[STEP_W-1:0];
        CFG_AXIS_STEP_Z:   cfg_nxt.step_z        = cfg_wdata[STEP_W-1:0];
        CFG_SPREAD_CUTOFF: cfg_nxt.spread_cutoff = cfg_wdata[CUTOFF_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_x        <= STEP_RESET;
      cfg_r.step_y        <= STEP_RESET;
      cfg_r.step_z        <= STEP_RESET;
      cfg_r.spread_cutoff <= CUTOFF_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wssc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .snap_push (snap_push),
    .snap_data (push_data),
    .snap_full (snap_full)
  );

  wssc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (snap_push),
    .wr_data (push_data),
    .full    (snap_full),
    .pop     (snap_pop),
    .rd_data (head_data),
    .empty   (snap_empty)
  );

  wssc_back #(
    .MAX_STATES (MAX_STATES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .snap_empty (snap_empty),
    .snap_data  (head_data),
    .snap_pop   (snap_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### design/wssc_checker.sv
// ---------------------------------------------------------------------------
// wssc_checker
// Port-level checks on the weighted spatial spread core, bound to the top.
// ---------------------------------------------------------------------------
`include "weighted_spatial_spread_core_defines.svh"

module wssc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input wssc_pkg::out_item_t             out_data
);
  import wssc_pkg::*;

  // hold a stalled result
  `WSSC_ASSERT_RUN(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // reset drops any pending result
  `WSSC_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")

  // a flagged state has a positive spread
  `WSSC_ASSERT_RUN(a_deloc_pos, out_valid && out_data.delocalized |-> out_data.spread > 48'sd0, "flag without positive spread")

  // a flagged state is counted
  `WSSC_ASSERT_RUN(a_deloc_cnt, out_valid && out_data.delocalized |-> out_data.delocalized_count != 13'd0, "flag with zero count")

endmodule

bind weighted_spatial_spread_core wssc_checker u_wssc_checker (.*);

### tb/weighted_spatial_spread_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// weighted_spatial_spread_core_test
// Streams grid samples into the spread core under several register settings
// and compares every per-state result against an in-bench spread predictor or a given value.
// ---------------------------------------------------------------------------
module weighted_spatial_spread_core_test;
  import wssc_pkg::*;

  localparam int     DRAIN_CYCLES   = 40;
  // slowest honest gap: a long output stall behind a full queue, well under this
  localparam int     WATCHDOG_LIMIT = 3000;
  localparam longint ACC_MAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN        = 64'sh8000_0000_0000_0000;
  localparam longint SPREAD_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SPREAD_MIN     = 64'shFFFF_8000_0000_0000;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_SPREAD_CUTOFF + 3'd1;
  localparam int     STALL_NONE     = 0;
  localparam int     STALL_CHOPPY   = 1;
  localparam int     STALL_LONG     = 2;

  typedef struct packed {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers and sums
  bit [15:0]   step_x = STEP_RESET, step_y = STEP_RESET, step_z = STEP_RESET;
  bit [46:0]   cutoff = '0;
  longint      acc_x = 0, acc_y = 0, acc_z = 0, acc_sq = 0;
  int unsigned state_num = 0, deloc_cnt = 0;

  out_item_t spread_due[$];
  dir_row_t  dir_table[$];

  int mismatches = 0, results_checked = 0, items_sent = 0, states_closed = 0;
  int deloc_seen = 0, sat_seen = 0, settings_used = 0, burst_left = 0;
  int stall_mode = STALL_NONE, mode_left = 0, stall_run = 0;
  bit stall_level = 1'b0;
  int quiet_cycles = 0;

  weighted_spatial_spread_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint add_sat(input longint a, input longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    case (s[64:63])
      2'b01:   return ACC_MAX;
      2'b10:   return ACC_MIN;
      default: return longint'(s[63:0]);
    endcase
  endfunction

  function automatic longint lin_part(input longint w, input longint c, input bit [15:0] step);
    return (w * c * longint'(step)) >>> 34;
  endfunction

  function automatic longint sq_part(input longint w, input longint c, input bit [15:0] step);
    bit [63:0] s, t;
    s = c * c;
    t = (s * step) >> 12;
    return longint'((t * w) >> 30);
  endfunction

  // floor(v^2 / 2^16), capped once |v| reaches 2^39
  function automatic bit [63:0] mean_square(input longint v);
    bit [63:0] m;
    bit [79:0] p;
    m = v[63] ? 64'd0 - v : v;
    if (m >= (64'd1 << 39)) return SQ_CAP;
    p = {16'd0, m} * {16'd0, m};
    return p[79:16];
  endfunction

  function automatic bit compute_spread(input in_item_t item, output out_item_t res);
    longint    a, w, sp;
    bit [63:0] means, s2, d;
    bit        dl;
    a = item.amplitude;
    w = a * a;
    res = '0;
    acc_x  = add_sat(acc_x, lin_part(w, item.x_coord, step_x));
    acc_y  = add_sat(acc_y, lin_part(w, item.y_coord, step_y));
    acc_z  = add_sat(acc_z, lin_part(w, item.z_coord, step_z));
    acc_sq = add_sat(acc_sq, sq_part(w, item.x_coord, step_x));
    acc_sq = add_sat(acc_sq, sq_part(w, item.y_coord, step_y));
    acc_sq = add_sat(acc_sq, sq_part(w, item.z_coord, step_z));
    if (!item.last_of_state) return 1'b0;

    means = mean_square(acc_x) + mean_square(acc_y) + mean_square(acc_z);
    s2 = acc_sq;
    if (s2 >= means) begin
      d = s2 - means;
      sp = (d > SPREAD_MAX) ? SPREAD_MAX : longint'(d);
    end else begin
      d = means - s2;
      sp = (d > SPREAD_MAX) ? SPREAD_MIN : -longint'(d);
    end
    dl = (sp > 0) && (sp > longint'(cutoff));
    if (dl && deloc_cnt < COUNT_MAX) deloc_cnt++;
    if (dl) deloc_seen++;
    if (sp == SPREAD_MAX || sp == SPREAD_MIN) sat_seen++;

    res.state_index       = state_num[11:0];
    res.spread            = sp[47:0];
    res.delocalized       = dl;
    res.delocalized_count = deloc_cnt[12:0];

    acc_x = 0; acc_y = 0; acc_z = 0; acc_sq = 0;
    if (state_num + 1 >= MAX_STATES_DEF) begin
      state_num = 0;
      deloc_cnt = 0;
    end else begin
      state_num++;
    end
    return 1'b1;
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (spread_due.size() == 0) begin
      $error("result for state %0d arrived with none expected", got.state_index);
      mismatches++;
      return;
    end
    want = spread_due.pop_front();
    results_checked++;
    if (got.state_index !== want.state_index) begin
      $error("state_index: expected %0d, got %0d", want.state_index, got.state_index);
      mismatches++;
    end
    if (got.spread !== want.spread) begin
      $error("spread: expected %0d, got %0d", want.spread, got.spread);
      mismatches++;
    end
    if (got.delocalized !== want.delocalized) begin
      $error("delocalized: expected %0b, got %0b", want.delocalized, got.delocalized);
      mismatches++;
    end
    if (got.delocalized_count !== want.delocalized_count) begin
      $error("delocalized_count: expected %0d, got %0d", want.delocalized_count,
             got.delocalized_count);
      mismatches++;
    end
  endfunction

  // Receiver: check, then pick the stall for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    if (mode_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
      mode_left  = $urandom_range(60, 400);
    end else begin
      mode_left--;
    end
    if (stall_run == 0) begin
      case (stall_mode)
        STALL_NONE: begin
          stall_level = 1'b0;
          stall_run   = 8;
        end
        STALL_CHOPPY: begin
          stall_level = ($urandom_range(0, 2) == 0);
          stall_run   = $urandom_range(0, 2);
        end
        default: begin
          stall_level = !stall_level;
          stall_run   = $urandom_range(1, stall_level ? 40 : 15);
        end
      endcase
    end else begin
      stall_run--;
    end
    out_stall <= stall_level;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d idle cycles, %0d results outstanding", quiet_cycles,
               spread_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dir_row_t plain_row(input int amp, input int x, input int y, input int z,
                                         input bit last);
    dir_row_t r;
    r = '0;
    r.item.amplitude     = amp[15:0];
    r.item.x_coord       = x[15:0];
    r.item.y_coord       = y[15:0];
    r.item.z_coord       = z[15:0];
    r.item.last_of_state = last;
    return r;
  endfunction

  function automatic dir_row_t known_row(input int amp, input int x, input int y, input int z,
                                         input int idx, input longint spr, input bit dl,
                                         input int cnt);
    dir_row_t r;
    r = plain_row(amp, x, y, z, 1'b1);
    r.typed                    = 1'b1;
    r.result.state_index       = idx[11:0];
    r.result.spread            = spr[47:0];
    r.result.delocalized       = dl;
    r.result.delocalized_count = cnt[12:0];
    return r;
  endfunction

  task automatic send_item(input in_item_t item, input bit use_given, input out_item_t given);
    int        gap;
    out_item_t due;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
    if (compute_spread(item, due)) spread_due.push_back(use_given ? given : due);
    if (item.last_of_state) states_closed++;
  endtask

  task automatic send_random_states(input int n_items);
    int       sent, len;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        it.amplitude     = ($urandom_range(0, 5) == 0) ? 16'sd0 : pick_word();
        it.x_coord       = pick_word();
        it.y_coord       = pick_word();
        it.z_coord       = pick_word();
        it.last_of_state = (k == len - 1);
        send_item(it, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  // One state of n identical samples; mirror flips the point's sign on odd samples
  task automatic send_state_run(input int n, input logic signed [15:0] amp,
                                input logic signed [15:0] x, input logic signed [15:0] y,
                                input logic signed [15:0] z, input bit mirror);
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      it.amplitude     = amp;
      it.x_coord       = (mirror && k[0]) ? -x : x;
      it.y_coord       = (mirror && k[0]) ? -y : y;
      it.z_coord       = (mirror && k[0]) ? -z : z;
      it.last_of_state = (k == n - 1);
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_AXIS_STEP_X:   step_x = data[15:0];
      CFG_AXIS_STEP_Y:   step_y = data[15:0];
      CFG_AXIS_STEP_Z:   step_z = data[15:0];
      CFG_SPREAD_CUTOFF: cutoff = data[46:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Hold the input, wait out every result, then let the pipe empty
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (spread_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    // default steps of 1.0, cutoff 0
    dir_table.push_back(known_row(0, 32767, -32768, 1, 0, 0, 1'b0, 0));
    dir_table.push_back(known_row(-32768, 0, 0, 0, 1, 0, 1'b0, 0));
    dir_table.push_back(known_row(-32768, 256, -256, 512, 2, 0, 1'b0, 0));
    dir_table.push_back(plain_row(-32768, 256, 0, 0, 1'b0));
    dir_table.push_back(known_row(-32768, -256, 0, 0, 3, 131072, 1'b1, 1));
    dir_table.push_back(plain_row(32767, 32767, 32767, 32767, 1'b1));
    dir_table.push_back(plain_row(-32768, -32768, -32768, -32768, 1'b1));
    dir_table.push_back(plain_row(1, -1, 1, -1, 1'b1));
    dir_table.push_back(plain_row(-1, 127, -128, 0, 1'b1));
    dir_table.push_back(plain_row(20000, 1000, -3000, 500, 1'b0));
    dir_table.push_back(plain_row(-15000, -2000, 4000, 0, 1'b0));
    dir_table.push_back(plain_row(32767, -32768, 32767, -32768, 1'b0));
    dir_table.push_back(plain_row(-32768, 32767, -32768, 32767, 1'b1));
    dir_table.push_back(plain_row(16384, -32768, 0, 32767, 1'b0));
    dir_table.push_back(plain_row(0, 0, 0, 0, 1'b1));
    // same point thrice: unnormalised weights drive the spread negative
    dir_table.push_back(plain_row(-32768, 25600, 0, 0, 1'b0));
    dir_table.push_back(plain_row(-32768, 25600, 0, 0, 1'b0));
    dir_table.push_back(plain_row(-32768, 25600, 0, 0, 1'b1));
    dir_table.push_back(plain_row(-32768, -32768, 32767, -32768, 1'b1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings
    settings_used++;
    foreach (dir_table[i]) send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].result);
    send_random_states(250);
    settle();

    // widest steps, zero cutoff; junk above the step bits must be dropped
    settings_used++;
    write_reg(CFG_AXIS_STEP_X, {31'($urandom), 16'hFFFF});
    write_reg(CFG_AXIS_STEP_Y, {31'($urandom), 16'hFFFF});
    write_reg(CFG_AXIS_STEP_Z, {31'($urandom), 16'hFFFF});
    write_reg(CFG_SPREAD_CUTOFF, '0);
    send_state_run(40, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    send_random_states(250);
    settle();

    // zero steps, top cutoff, and a write to an index with no register
    settings_used++;
    write_reg(CFG_AXIS_STEP_X, '0);
    write_reg(CFG_AXIS_STEP_Y, '0);
    write_reg(CFG_AXIS_STEP_Z, '0);
    write_reg(CFG_SPREAD_CUTOFF, '1);
    write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'({$urandom, $urandom}));
    send_random_states(250);
    settle();

    settings_used++;
    write_reg(CFG_AXIS_STEP_X, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(CFG_AXIS_STEP_Y, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(CFG_AXIS_STEP_Z, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(CFG_SPREAD_CUTOFF, CFG_DATA_W'({$urandom, $urandom} >> $urandom_range(10, 40)));
    send_random_states(300);
    settle();

    // low cutoff
    settings_used++;
    write_reg(CFG_AXIS_STEP_X, CFG_DATA_W'(STEP_RESET));
    write_reg(CFG_AXIS_STEP_Y, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(CFG_AXIS_STEP_Z, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(CFG_SPREAD_CUTOFF, CFG_DATA_W'($urandom_range(0, 32'h00FF_FFFF)));
    send_random_states(350);
    settle();

    $display("%0d samples over %0d states under %0d register settings; %0d results checked",
             items_sent, states_closed, settings_used, results_checked);
    $display("%0d states flagged delocalised, %0d with a clamped spread", deloc_seen, sat_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
